// ===== design/ght_pkg.sv =====
// ----------------------------------------------------------------------------
// ght_pkg: shared types and codes for the generational handle table
// Slot entry layout, command codes and kind codes.
// ----------------------------------------------------------------------------
package ght_pkg;

  typedef logic [2:0]  cmd_t;
  typedef logic [1:0]  kind_t;
  typedef logic [15:0] owner_t;
  typedef logic [15:0] gen_t;
  typedef logic [31:0] word_t;
  typedef logic [6:0]  count_t;

  localparam cmd_t CMD_CREATE        = 3'd0;
  localparam cmd_t CMD_DESTROY       = 3'd1;
  localparam cmd_t CMD_DESTROY_OWNER = 3'd2;
  localparam cmd_t CMD_GET           = 3'd3;
  localparam cmd_t CMD_SET           = 3'd4;

  localparam kind_t KIND_FREE   = 2'd0;
  localparam kind_t KIND_MUTEX  = 2'd1;
  localparam kind_t KIND_THREAD = 2'd2;

  localparam owner_t OWNER_ANY = 16'd0;
  localparam count_t COUNT_MAX = 7'd127;

  typedef struct packed {
    gen_t   gen;
    owner_t owner;
    kind_t  kind;
    word_t  data;
  } slot_t;

endpackage

// ===== design/ght_slot_ram.sv =====
// ----------------------------------------------------------------------------
// ght_slot_ram: slot entry storage
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ght_slot_ram #(
  parameter int SLOTS = 64,
  localparam int AW = $clog2(SLOTS)
) (
  input  logic            clk,
  input  logic [AW-1:0]   rd_addr,
  output ght_pkg::slot_t  rd_data,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  ght_pkg::slot_t  wr_data
);
  import ght_pkg::*;

  slot_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== design/generational_handle_table.sv =====
// ----------------------------------------------------------------------------
// generational_handle_table: handle table with per-slot generation counts
// Create, destroy, destroy-by-owner, get and set over a slot memory.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one command per transfer;
//   output channel (out_valid/out_stall) returns exactly one result per
//   command, in order. in_stall is high while a command is in progress.
//   The edge that raises out_valid also returns the block to idle, ready for
//   the next command. Destroy, get, set on an in-range index: the slot is
//   read at the transfer, then checked and written in the execute state.
//   Bad-kind create, create on a table known full, out-of-range index and
//   unknown commands: reported straight from the transfer.
//   Create: scans the slot memory one entry per cycle from the lowest-free
//   hint until it finds a free entry or runs off the end; usually the hint
//   is the answer.
//   Destroy-owner: walks slots 1..SLOTS-1 through the read port. Reset: a
//   clearing pass writes every slot to zero, with in_stall held high. A
//   stalled result stays in the output register; a finished command waits
//   for that register to drain.
// ----------------------------------------------------------------------------
module generational_handle_table #(
  parameter int SLOTS = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  ght_pkg::cmd_t    command,
  input  ght_pkg::word_t   handle_value,
  input  ght_pkg::owner_t  owner_id,
  input  ght_pkg::kind_t   handle_kind,
  input  ght_pkg::word_t   data_word,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             ok,
  output ght_pkg::word_t   handle_out,
  output ght_pkg::word_t   data_out,
  output ght_pkg::kind_t   freed_kind,
  output ght_pkg::count_t  freed_count
);
  import ght_pkg::*;

  localparam int AW = $clog2(SLOTS);
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);
  localparam logic [16:0]   SLOTS_H = 17'(SLOTS);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_EXEC  = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_WALK  = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]    state;
  logic [CW-1:0] ptr;        // clear / scan / walk address
  logic          chk_vld;    // rd_data belongs to chk_addr
  logic [AW-1:0] chk_addr;
  logic [CW-1:0] low_free;   // every slot from 1 to below this is in use
  count_t        cnt;

  cmd_t          cmd_q;
  logic [AW-1:0] idx_q;
  owner_t        owner_q;
  kind_t         kind_q;
  word_t         data_q;

  logic          res_ok;
  word_t         res_handle;
  word_t         res_data;
  kind_t         res_fkind;
  count_t        res_fcnt;

  logic [AW-1:0] mem_rd_addr;
  slot_t         rd;
  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  slot_t         mem_wr_data;

  ght_slot_ram #(.SLOTS(SLOTS)) u_ram (
    .clk     (clk),
    .rd_addr (mem_rd_addr),
    .rd_data (rd),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  logic       in_xfer;
  logic       idx_ok;
  logic       scan_issue;
  logic       free_hit;
  logic       walk_match;
  logic       live;
  logic       destroy_ok;
  logic       get_ok;
  logic       set_ok;
  logic       out_load;
  gen_t       gen_inc;

  assign in_stall = (state != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign idx_ok   = (handle_value[15:0] != 16'd0) && ({1'b0, handle_value[15:0]} < SLOTS_H);

  assign scan_issue = (ptr < SLOTS_C);
  assign free_hit   = chk_vld && (rd.kind == KIND_FREE);
  assign walk_match = chk_vld && ((owner_q == OWNER_ANY) || (rd.owner == owner_q));
  assign gen_inc    = gen_t'(rd.gen + 16'd1);

  // lookup command checks, valid in ST_EXEC (index range already checked)
  assign live       = (rd.kind != KIND_FREE);
  assign destroy_ok = (cmd_q == CMD_DESTROY) && live && (owner_q != OWNER_ANY)
                      && (rd.owner == owner_q);
  assign get_ok     = (cmd_q == CMD_GET) && live
                      && ((owner_q == OWNER_ANY) || (rd.owner == owner_q))
                      && ((kind_q == KIND_FREE) || (rd.kind == kind_q));
  assign set_ok     = (cmd_q == CMD_SET) && live;

  assign out_load = (state == ST_DONE) && (!out_valid || !out_stall);

  // read port: handle index straight from the input in idle, else the clear / scan / walk address
  always_comb begin
    if (state == ST_IDLE) begin
      mem_rd_addr = handle_value[AW-1:0];
    end else begin
      mem_rd_addr = ptr[AW-1:0];
    end
  end

  // write port
  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = chk_addr;
    mem_wr_data = '0;
    unique case (state) inside
      ST_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = ptr[AW-1:0];
      end
      ST_SCAN: begin
        mem_wr_en   = free_hit;
        mem_wr_data = '{gen: gen_inc, owner: owner_q, kind: kind_q, data: data_q};
      end
      ST_WALK: begin
        mem_wr_en       = walk_match;
        mem_wr_data.gen = rd.gen;
      end
      ST_EXEC: begin
        mem_wr_en   = destroy_ok || set_ok;
        mem_wr_addr = idx_q;
        if (destroy_ok) begin
          mem_wr_data.gen = rd.gen;
        end else begin
          mem_wr_data      = rd;
          mem_wr_data.data = data_q;
        end
      end
      ST_IDLE, ST_DONE: begin
        mem_wr_en = 1'b0;
      end
      default: begin
        mem_wr_en = 1'b0;
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      ptr      <= '0;
      chk_vld  <= 1'b0;
      low_free <= CW'(1);
      cnt      <= '0;
    end else begin
      chk_vld <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          if (ptr == SLOTS_C - CW'(1)) begin
            state <= ST_IDLE;
          end
          ptr <= ptr + CW'(1);
        end
        ST_IDLE: begin
          if (in_xfer) begin
            cmd_q      <= command;
            idx_q      <= handle_value[AW-1:0];
            owner_q    <= owner_id;
            kind_q     <= handle_kind;
            data_q     <= data_word;
            res_ok     <= 1'b0;
            res_handle <= '0;
            res_data   <= '0;
            res_fkind  <= KIND_FREE;
            res_fcnt   <= '0;
            cnt        <= '0;
            state      <= ST_DONE;
            unique case (command) inside
              CMD_CREATE: begin
                if ((handle_kind == KIND_MUTEX || handle_kind == KIND_THREAD)
                    && low_free < SLOTS_C) begin
                  ptr   <= low_free;
                  state <= ST_SCAN;
                end
              end
              CMD_DESTROY_OWNER: begin
                ptr   <= CW'(1);
                state <= ST_WALK;
              end
              CMD_DESTROY, CMD_GET, CMD_SET: begin
                if (idx_ok) begin
                  state <= ST_EXEC;
                end
              end
              default: begin
                state <= ST_DONE;
              end
            endcase
          end
        end
        ST_EXEC: begin
          res_ok <= destroy_ok || get_ok || set_ok;
          if (destroy_ok || get_ok) begin
            res_data <= rd.data;
          end
          if (destroy_ok) begin
            res_fkind <= rd.kind;
            if (CW'(idx_q) < low_free) begin
              low_free <= CW'(idx_q);
            end
          end
          state <= ST_DONE;
        end
        ST_SCAN: begin
          if (free_hit) begin
            res_ok     <= 1'b1;
            res_handle <= {gen_inc, 16'(chk_addr)};
            low_free   <= CW'(chk_addr) + CW'(1);
            state      <= ST_DONE;
          end else if (!chk_vld && !scan_issue) begin
            low_free <= SLOTS_C;  // table full
            state    <= ST_DONE;
          end else begin
            chk_vld  <= scan_issue;
            chk_addr <= ptr[AW-1:0];
            if (scan_issue) begin
              ptr <= ptr + CW'(1);
            end
          end
        end
        ST_WALK: begin
          if (walk_match && rd.kind != KIND_FREE && cnt != COUNT_MAX) begin
            cnt <= cnt + 7'd1;
          end
          if (!chk_vld && !scan_issue) begin
            res_ok   <= 1'b1;
            res_fcnt <= cnt;
            low_free <= CW'(1);
            state    <= ST_DONE;
          end else begin
            chk_vld  <= scan_issue;
            chk_addr <= ptr[AW-1:0];
            if (scan_issue) begin
              ptr <= ptr + CW'(1);
            end
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      ok          <= res_ok;
      handle_out  <= res_handle;
      data_out    <= res_data;
      freed_kind  <= res_fkind;
      freed_count <= res_fcnt;
    end
  end

endmodule

// ===== design/ght_checker.sv =====
// ----------------------------------------------------------------------------
// ght_checker: port-level checks for the generational handle table
// Result consistency, output hold under stall and reset behavior.
// ----------------------------------------------------------------------------
module ght_checker (
  input logic             clk,
  input logic             rst,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic             ok,
  input ght_pkg::word_t   handle_out,
  input ght_pkg::word_t   data_out,
  input ght_pkg::kind_t   freed_kind,
  input ght_pkg::count_t  freed_count
);
  import ght_pkg::*;

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(ok) && $stable(handle_out)
      && $stable(data_out) && $stable(freed_kind) && $stable(freed_count))
    else $error("stalled result changed");

  // refused commands report nothing
  a_refused: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> handle_out == 32'd0 && data_out == 32'd0
      && freed_kind == KIND_FREE && freed_count == 7'd0)
    else $error("refused command with nonzero fields");

  // slot 0 is never handed out
  a_slot0: assert property (@(posedge clk) disable iff (rst)
    out_valid && handle_out != 32'd0 |-> ok && handle_out[15:0] != 16'd0
      && data_out == 32'd0 && freed_kind == KIND_FREE)
    else $error("bad create result");

  // a destroy result carries no handle and no count
  a_destroy: assert property (@(posedge clk) disable iff (rst)
    out_valid && freed_kind != KIND_FREE |-> ok && handle_out == 32'd0
      && freed_count == 7'd0 && freed_kind != 2'd3)
    else $error("bad destroy result");

  // reset empties the output and starts the clearing pass
  a_reset: assert property (@(posedge clk)
    rst |=> in_stall && !out_valid)
    else $error("reset did not stall input");

endmodule

bind generational_handle_table ght_checker u_ght_checker (.*);

// ===== tb/sv/handle_table_checker.sv =====
// ----------------------------------------------------------------------------
// handle_table_checker: result checker for the generational handle table
// Watches both channels, keeps a shadow copy of the slot table, predicts the
// reply to every accepted command and compares replies in order.
// ----------------------------------------------------------------------------
module handle_table_checker #(
  parameter int SLOTS = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_stall,
  input  ght_pkg::cmd_t   command,
  input  ght_pkg::word_t  handle_value,
  input  ght_pkg::owner_t owner_id,
  input  ght_pkg::kind_t  handle_kind,
  input  ght_pkg::word_t  data_word,
  input  logic            out_valid,
  input  logic            out_stall,
  input  logic            ok,
  input  ght_pkg::word_t  handle_out,
  input  ght_pkg::word_t  data_out,
  input  ght_pkg::kind_t  freed_kind,
  input  ght_pkg::count_t freed_count,
  output int              fail_count,
  output int              pending,
  output int              compared,
  output int              full_refusals
);
  import ght_pkg::*;

  typedef struct packed {
    logic   ok;
    word_t  handle;
    word_t  data;
    kind_t  kind;
    count_t count;
  } table_reply_t;

  owner_t tbl_owner [SLOTS];
  kind_t  tbl_kind  [SLOTS];
  word_t  tbl_data  [SLOTS];
  gen_t   tbl_gen   [SLOTS];

  table_reply_t reply_q [$];
  int n_fail;
  int n_compared;
  int n_full;

  // shadow table update; returns the reply the block owes for this command
  function automatic table_reply_t apply_command(cmd_t cmd, word_t hv, owner_t own,
                                                 kind_t knd, word_t dat);
    table_reply_t r;
    int           idx;
    bit           placed;
    r = '0;
    idx = int'(hv[15:0]);
    if (idx == 0 || idx >= SLOTS) idx = 0;
    else if (tbl_kind[idx] == KIND_FREE) idx = 0;
    case (cmd)
      CMD_CREATE: begin
        if (knd == KIND_MUTEX || knd == KIND_THREAD) begin
          placed = 1'b0;
          for (int i = 1; i < SLOTS && !placed; i++) begin
            if (tbl_kind[i] == KIND_FREE) begin
              tbl_gen[i]   = tbl_gen[i] + 16'd1;
              tbl_owner[i] = own;
              tbl_kind[i]  = knd;
              tbl_data[i]  = dat;
              r.ok     = 1'b1;
              r.handle = {tbl_gen[i], 16'(i)};
              placed   = 1'b1;
            end
          end
          if (!placed) n_full++;
        end
      end
      CMD_DESTROY: begin
        if (idx != 0 && own != OWNER_ANY && tbl_owner[idx] == own) begin
          r.ok   = 1'b1;
          r.data = tbl_data[idx];
          r.kind = tbl_kind[idx];
          tbl_owner[idx] = OWNER_ANY;
          tbl_kind[idx]  = KIND_FREE;
          tbl_data[idx]  = '0;
        end
      end
      CMD_DESTROY_OWNER: begin
        for (int i = 1; i < SLOTS; i++) begin
          if (own == OWNER_ANY || tbl_owner[i] == own) begin
            if (tbl_kind[i] != KIND_FREE && r.count != COUNT_MAX) r.count++;
            tbl_owner[i] = OWNER_ANY;
            tbl_kind[i]  = KIND_FREE;
            tbl_data[i]  = '0;
          end
        end
        r.ok = 1'b1;
      end
      CMD_GET: begin
        if (idx != 0 && (own == OWNER_ANY || tbl_owner[idx] == own) &&
            (knd == KIND_FREE || tbl_kind[idx] == knd)) begin
          r.ok   = 1'b1;
          r.data = tbl_data[idx];
        end
      end
      CMD_SET: begin
        if (idx != 0) begin
          tbl_data[idx] = dat;
          r.ok = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // one line per mismatch
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    n_fail++;
    $display("checker: mismatch on %s at reply %0d: got %h, expected %h",
             what, n_compared, got, want);
  endtask

  always @(posedge clk) begin
    table_reply_t want;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        tbl_owner[i] = '0;
        tbl_kind[i]  = KIND_FREE;
        tbl_data[i]  = '0;
        tbl_gen[i]   = '0;
      end
      reply_q.delete();
      n_fail     = 0;
      n_compared = 0;
      n_full     = 0;
    end else begin
      if (in_valid && !in_stall)
        reply_q.push_back(apply_command(command, handle_value, owner_id,
                                        handle_kind, data_word));
      if (out_valid && !out_stall) begin
        if (reply_q.size() == 0) begin
          report_mismatch("unexpected reply, handle_out", handle_out, '0);
        end else begin
          want = reply_q.pop_front();
          if (ok !== want.ok)
            report_mismatch("ok", 32'(ok), 32'(want.ok));
          if (handle_out !== want.handle)
            report_mismatch("handle_out", handle_out, want.handle);
          if (data_out !== want.data)
            report_mismatch("data_out", data_out, want.data);
          if (freed_kind !== want.kind)
            report_mismatch("freed_kind", 32'(freed_kind), 32'(want.kind));
          if (freed_count !== want.count)
            report_mismatch("freed_count", 32'(freed_count), 32'(want.count));
          n_compared++;
        end
      end
    end
    fail_count    <= n_fail;
    pending       <= reply_q.size();
    compared      <= n_compared;
    full_refusals <= n_full;
  end

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: top level for the generational handle table
// Drives directed and random command streams with bursty input and a
// patterned output stall, and reports the verdict from the checker's count.
// ----------------------------------------------------------------------------
module testbench;
  import ght_pkg::*;

  localparam int SLOTS        = 64;
  localparam int RANDOM_ITEMS = 1430;
  localparam int LONG_HOLD    = 400;      // one long output hold, in cycles
  localparam int CYCLE_LIMIT  = 1000000;  // watchdog limit, in cycles

  // codes the block must refuse; not part of the package
  localparam cmd_t  CMD_UNUSED_A = 3'd5;
  localparam cmd_t  CMD_UNUSED_B = 3'd6;
  localparam cmd_t  CMD_UNUSED_C = 3'd7;
  localparam kind_t KIND_BAD     = 2'd3;

  logic   clk          = 1'b0;
  logic   rst          = 1'b1;
  logic   in_valid     = 1'b0;
  cmd_t   command      = CMD_CREATE;
  word_t  handle_value = '0;
  owner_t owner_id     = OWNER_ANY;
  kind_t  handle_kind  = KIND_FREE;
  word_t  data_word    = '0;
  logic   out_stall    = 1'b0;

  logic   in_stall;
  logic   out_valid;
  logic   ok;
  word_t  handle_out;
  word_t  data_out;
  kind_t  freed_kind;
  count_t freed_count;

  int fail_count;
  int pending;
  int compared;
  int full_refusals;

  // per-command tallies of what was actually transferred
  int n_create, n_destroy, n_purge, n_get, n_set, n_unknown;
  int cycles = 0;

  // long-hold handshake between the sender and the receiver process
  bit hold_req  = 1'b0;
  bit hold_done = 1'b0;

  always #6 clk = ~clk;

  generational_handle_table #(
    .SLOTS(SLOTS)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .handle_value(handle_value),
    .owner_id    (owner_id),
    .handle_kind (handle_kind),
    .data_word   (data_word),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .ok          (ok),
    .handle_out  (handle_out),
    .data_out    (data_out),
    .freed_kind  (freed_kind),
    .freed_count (freed_count)
  );

  handle_table_checker #(
    .SLOTS(SLOTS)
  ) u_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .handle_value (handle_value),
    .owner_id     (owner_id),
    .handle_kind  (handle_kind),
    .data_word    (data_word),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .ok           (ok),
    .handle_out   (handle_out),
    .data_out     (data_out),
    .freed_kind   (freed_kind),
    .freed_count  (freed_count),
    .fail_count   (fail_count),
    .pending      (pending),
    .compared     (compared),
    .full_refusals(full_refusals)
  );

  // Watchdog. Covers the clearing pass after reset, the long hold and every
  // command taking the full destroy-owner walk with worst-case stalls.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: timeout after %0d cycles, %0d replies outstanding",
               cycles, pending);
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Present one command and hold it until the transfer. Called at a rising
  // edge; returns at the edge where the block took it, with valid still high
  // so back-to-back commands keep valid asserted between them.
  task automatic send_cmd(cmd_t c, word_t h, owner_t o, kind_t k, word_t d);
    in_valid     <= 1'b1;
    command      <= c;
    handle_value <= h;
    owner_id     <= o;
    handle_kind  <= k;
    data_word    <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    case (c)
      CMD_CREATE:        n_create++;
      CMD_DESTROY:       n_destroy++;
      CMD_DESTROY_OWNER: n_purge++;
      CMD_GET:           n_get++;
      CMD_SET:           n_set++;
      default:           n_unknown++;
    endcase
  endtask

  task automatic idle_gap(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Stop sending until every outstanding reply has come back. The first edge
  // lets the checker's count catch up with the last transfer.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Owners cluster on a small pool so ownership checks match often.
  function automatic owner_t random_owner();
    int r;
    r = $urandom_range(99);
    if (r < 85)      return owner_t'($urandom_range(1, 4));
    else if (r < 92) return OWNER_ANY;
    else             return owner_t'($urandom_range(65535));
  endfunction

  // Mostly live-range indexes; the generation half is noise since the
  // block never compares it. The rest hits index 0, just past the end, or
  // anywhere in 16 bits.
  function automatic word_t random_handle();
    logic [15:0] idx;
    int          r;
    r = $urandom_range(99);
    if (r < 85)      idx = 16'($urandom_range(1, SLOTS - 1));
    else if (r < 90) idx = '0;
    else if (r < 95) idx = 16'($urandom_range(SLOTS, SLOTS + 8));
    else             idx = 16'($urandom_range(65535));
    return {16'($urandom_range(65535)), idx};
  endfunction

  // create_pct steers occupancy: a high share fills the table to the brim,
  // a low one keeps it sparse so lookups often land on free slots.
  task automatic random_command(int create_pct);
    cmd_t   c;
    kind_t  k;
    owner_t o;
    int     r;
    o = random_owner();
    k = $urandom_range(1) ? KIND_THREAD : KIND_MUTEX;
    r = $urandom_range(99);
    if (r < create_pct) begin
      c = CMD_CREATE;
      if ($urandom_range(19) == 0) k = $urandom_range(1) ? KIND_FREE : KIND_BAD;
    end else begin
      r = $urandom_range(99);
      if (r < 35) begin
        c = CMD_DESTROY;
      end else if (r < 65) begin
        c = CMD_GET;
        k = kind_t'($urandom_range(3));
      end else if (r < 88) begin
        c = CMD_SET;
      end else if (r < 96) begin
        c = CMD_DESTROY_OWNER;
        // wiping the whole table should stay rare
        if (o == OWNER_ANY && $urandom_range(3) != 0) o = random_owner();
      end else begin
        c = cmd_t'($urandom_range(CMD_UNUSED_A, CMD_UNUSED_C));
      end
    end
    send_cmd(c, random_handle(), o, k, $urandom());
  endtask

  // Receiver: stretches of no stall, coin-flip stall and a fixed duty
  // pattern, plus one long hold once the random traffic starts so the
  // block backs up into its input.
  initial begin
    int mode;
    int span;
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        mode = $urandom_range(2);
        span = $urandom_range(10, 80);
        for (int c = 0; c < span; c++) begin
          case (mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= 1'($urandom_range(1));
            default: out_stall <= (c % 7) < 3;
          endcase
          @(posedge clk);
        end
      end
    end
  end

  initial begin
    int seg_left;
    int burst_left;
    int create_pct;
    n_create  = 0;
    n_destroy = 0;
    n_purge   = 0;
    n_get     = 0;
    n_set     = 0;
    n_unknown = 0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: slot 1 and 2 get generation 1; then the refusal paths but a full table,
    // the extremes of data and owner, and unknown opcodes.
    send_cmd(CMD_CREATE, '0, owner_t'(1), KIND_MUTEX, 32'hFFFF_FFFF);
    send_cmd(CMD_CREATE, '1, 16'hFFFF, KIND_THREAD, '0);
    send_cmd(CMD_CREATE, '0, owner_t'(1), KIND_FREE, 32'h1111_1111);   // bad kind
    send_cmd(CMD_CREATE, '0, owner_t'(1), KIND_BAD, 32'h2222_2222);    // bad kind
    send_cmd(CMD_GET, 32'h0001_0001, OWNER_ANY, KIND_FREE, '0);       // any owner, any kind
    send_cmd(CMD_GET, 32'h0001_0001, owner_t'(1), KIND_BAD, '0);      // kind never stored
    send_cmd(CMD_GET, 32'h0001_0002, owner_t'(1), KIND_THREAD, '0);   // wrong owner
    send_cmd(CMD_GET, 32'h0001_0000, OWNER_ANY, KIND_FREE, '0);       // index 0
    send_cmd(CMD_GET, {16'h0001, 16'(SLOTS)}, OWNER_ANY, KIND_FREE, '0);  // past the end
    send_cmd(CMD_GET, 32'hFFFF_FFFF, OWNER_ANY, KIND_FREE, '1);
    send_cmd(CMD_SET, 32'h0001_0002, owner_t'(7), KIND_FREE, 32'hA5A5_5A5A);  // owner ignored
    send_cmd(CMD_SET, 32'h0000_0005, owner_t'(1), KIND_FREE, 32'h5A5A_A5A5);  // free slot
    send_cmd(CMD_DESTROY, 32'h0001_0001, OWNER_ANY, KIND_FREE, '0);   // owner 0 refused
    send_cmd(CMD_DESTROY, 32'h0001_0001, owner_t'(2), KIND_FREE, '0); // wrong owner
    send_cmd(CMD_DESTROY, 32'hFFFF_0001, owner_t'(1), KIND_FREE, '0); // stale gen ignored
    send_cmd(CMD_DESTROY, 32'h0001_0001, owner_t'(1), KIND_FREE, '0); // already free
    send_cmd(CMD_CREATE, '0, owner_t'(3), KIND_MUTEX, 32'h1234_5678); // slot 1, generation 2
    send_cmd(CMD_DESTROY_OWNER, '0, 16'hFFFF, KIND_FREE, '0);
    send_cmd(CMD_DESTROY_OWNER, '0, OWNER_ANY, KIND_FREE, '0);        // wipe everything
    send_cmd(CMD_UNUSED_A, '1, 16'hFFFF, KIND_BAD, '1);
    send_cmd(CMD_UNUSED_B, '1, 16'hFFFF, KIND_BAD, '1);
    send_cmd(CMD_UNUSED_C, '1, 16'hFFFF, KIND_BAD, '1);
    send_cmd(CMD_GET, 32'h0002_0001, OWNER_ANY, KIND_FREE, '0);       // freed slot
    drain_results();

    // Random: segments with their own create share, bursty sender,
    // occasional full drains between segments.
    hold_req   = 1'b1;
    seg_left   = 0;
    burst_left = $urandom_range(1, 40);
    create_pct = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(50, 150);
        case ($urandom_range(2))
          0:       create_pct = 20;
          1:       create_pct = 45;
          default: create_pct = 85;
        endcase
        if ($urandom_range(3) == 0) drain_results();
      end
      if (burst_left == 0) begin
        idle_gap($urandom_range(1, 10));
        burst_left = $urandom_range(1, 40);
      end
      random_command(create_pct);
      seg_left--;
      burst_left--;
    end

    drain_results();
    // every command answers, but let any trailing activity show up
    repeat (SLOTS + 8) @(posedge clk);

    $display("testbench: %0d commands sent (create %0d, destroy %0d, destroy-owner %0d,",
             n_create + n_destroy + n_purge + n_get + n_set + n_unknown,
             n_create, n_destroy, n_purge);
    $display("testbench:   get %0d, set %0d, unknown %0d); %0d replies checked, %0d full-table refusals",
             n_get, n_set, n_unknown, compared, full_refusals);
    if (fail_count == 0 && pending == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule
